FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms, clocked on clk_i, disabled in reset
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain property
`define NOAM_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define NOAM_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define NOAM_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/noam_pkg.sv
// ----------------------------------------------------------------------------
// noam_pkg
// types, constants and helpers of the nearest object associate/merge core
// ----------------------------------------------------------------------------
package noam_pkg;

  localparam int unsigned MAX_OBJECTS_DEF = 64;

  localparam int unsigned CLASS_W  = 5;
  localparam int unsigned POS_W    = 24;
  localparam int unsigned W16      = 16;
  localparam int unsigned OBJ_ID_W = 7;
  localparam int unsigned SQ_W     = 2 * POS_W;
  localparam int unsigned DIST_W   = SQ_W + 2;
  localparam int unsigned R2_W     = 2 * W16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CLASS_W-1:0] CLASS_BOTTLE  = 5'd5;
  localparam logic [CLASS_W-1:0] CLASS_CHAIR   = 5'd9;
  localparam logic [CLASS_W-1:0] CLASS_MONITOR = 5'd20;

  // 0.6 m, 0.2 m, 1.0 m and 0.5 m in 1/1024 m
  localparam logic [W16-1:0] RADIUS_DEFAULT_RST = 16'd614;
  localparam logic [W16-1:0] RADIUS_BOTTLE_RST  = 16'd205;
  localparam logic [W16-1:0] RADIUS_CHAIR_RST   = 16'd1024;
  localparam logic [W16-1:0] RADIUS_MONITOR_RST = 16'd512;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS_DEFAULT = 2'd0,
    CFG_RADIUS_BOTTLE  = 2'd1,
    CFG_RADIUS_CHAIR   = 2'd2,
    CFG_RADIUS_MONITOR = 2'd3
  } cfg_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_DECIDE,
    ST_MERGE
  } noam_state_e;

  typedef struct packed {
    logic [CLASS_W-1:0]      category;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic [W16-1:0]          confidence;
    logic [W16-1:0]          extent;
  } noam_item_t;

  typedef struct packed {
    logic [OBJ_ID_W-1:0] entry_num;
    logic                was_merged;
    logic                table_full;
  } noam_result_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic rd_best;
    logic merge_wr;
    logic append_wr;
    logic report_full;
  } noam_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic pipe_busy;
    logic match;
    logic full;
  } noam_sts_t;

  function automatic logic [POS_W-1:0] abs_diff(logic signed [POS_W-1:0] a,
                                                 logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] ae;
    logic signed [POS_W:0] be;
    logic signed [POS_W:0] d;
    ae = {a[POS_W-1], a};
    be = {b[POS_W-1], b};
    d  = (ae >= be) ? (ae - be) : (be - ae);
    return d[POS_W-1:0];
  endfunction

  function automatic logic signed [POS_W-1:0] mean_pos(logic signed [POS_W-1:0] a,
                                                       logic signed [POS_W-1:0] b);
    logic signed [POS_W:0] s;
    s = {a[POS_W-1], a} + {b[POS_W-1], b};
    return s[POS_W:1];
  endfunction

  function automatic logic [W16-1:0] mean_u16(logic [W16-1:0] a, logic [W16-1:0] b);
    logic [W16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[W16:1];
  endfunction

endpackage

FILE: hw/rtl/noam_ram.sv
// ----------------------------------------------------------------------------
// noam_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module noam_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hw/rtl/noam_ctrl.sv
// ----------------------------------------------------------------------------
// noam_ctrl
// sequencer: scan, drain, decide, merge or append, report
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module noam_ctrl import noam_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  noam_sts_t sts_i,
  output noam_cmd_t cmd_o
);

  noam_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sts_i.scan_done) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          state_d = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_d = sts_i.match ? ST_MERGE : ST_IDLE;
      end
      ST_MERGE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    unique case (state_q)
      ST_IDLE: begin
        busy_o     = 1'b0;
        cmd_o.load = start_i;
      end
      ST_SCAN: begin
        cmd_o.scan = !sts_i.scan_done;
      end
      ST_DRAIN: begin
      end
      ST_DECIDE: begin
        priority if (sts_i.match) begin
          cmd_o.rd_best = 1'b1;
        end else if (sts_i.full) begin
          cmd_o.report_full = 1'b1;
        end else begin
          cmd_o.append_wr = 1'b1;
        end
      end
      ST_MERGE: begin
        cmd_o.merge_wr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  `NOAM_ASSERT_NEXT(a_start_scans, start_i && !busy_o, state_q == ST_SCAN, "start not taken")
  `NOAM_ASSERT_IMPLIES(a_decide_drained, state_q == ST_DECIDE, !sts_i.pipe_busy,
                       "decision while scan pipeline busy")
  `NOAM_ASSERT_IMPLIES(a_merge_after_decide, state_q == ST_MERGE,
                       $past(state_q) == ST_DECIDE, "merge without decision")

endmodule

FILE: hw/rtl/noam_dp.sv
// ----------------------------------------------------------------------------
// noam_dp
// entry store, distance pipeline, best tracker, merge/append and result
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module noam_dp import noam_pkg::*; #(
  parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  noam_cmd_t            cmd_i,
  output noam_sts_t            sts_o,
  input  noam_item_t           item_i,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [W16-1:0]       cfg_data_i,
  output logic                 result_valid_o,
  output noam_result_t         result_o
);

  localparam int unsigned IDX_W = $clog2(MAX_OBJECTS);
  localparam int unsigned CNT_W = $clog2(MAX_OBJECTS + 1);

  // radius registers
  logic [W16-1:0] rad_default_q, rad_bottle_q, rad_chair_q, rad_monitor_q;
  logic [W16-1:0] rad_sel;
  logic [R2_W-1:0] r2_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rad_default_q <= RADIUS_DEFAULT_RST;
      rad_bottle_q  <= RADIUS_BOTTLE_RST;
      rad_chair_q   <= RADIUS_CHAIR_RST;
      rad_monitor_q <= RADIUS_MONITOR_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_RADIUS_DEFAULT: rad_default_q <= cfg_data_i;
        CFG_RADIUS_BOTTLE:  rad_bottle_q  <= cfg_data_i;
        CFG_RADIUS_CHAIR:   rad_chair_q   <= cfg_data_i;
        CFG_RADIUS_MONITOR: rad_monitor_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // captured item
  noam_item_t item_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    unique case (item_q.category)
      CLASS_BOTTLE:  rad_sel = rad_bottle_q;
      CLASS_CHAIR:   rad_sel = rad_chair_q;
      CLASS_MONITOR: rad_sel = rad_monitor_q;
      default:       rad_sel = rad_default_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    r2_q <= R2_W'(rad_sel) * R2_W'(rad_sel);
  end

  // entry count and scan counter
  logic [CNT_W-1:0] count_q, scan_cnt_q;
  logic [IDX_W-1:0] best_idx_q;
  logic             found_q;
  logic [DIST_W-1:0] best_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      scan_cnt_q <= '0;
    end else begin
      if (cmd_i.load) begin
        scan_cnt_q <= '0;
      end else if (cmd_i.scan) begin
        scan_cnt_q <= scan_cnt_q + 1'b1;
      end
      if (cmd_i.append_wr) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // entry store
  noam_item_t       rdata, wdata, merged;
  logic             ram_we, ram_re;
  logic [IDX_W-1:0] ram_waddr, ram_raddr;

  assign ram_re    = cmd_i.scan || cmd_i.rd_best;
  assign ram_raddr = cmd_i.rd_best ? best_idx_q : scan_cnt_q[IDX_W-1:0];
  assign ram_we    = cmd_i.merge_wr || cmd_i.append_wr;
  assign ram_waddr = cmd_i.merge_wr ? best_idx_q : count_q[IDX_W-1:0];

  always_comb begin
    merged.category   = rdata.category;
    merged.pos_x      = mean_pos(rdata.pos_x, item_q.pos_x);
    merged.pos_y      = mean_pos(rdata.pos_y, item_q.pos_y);
    merged.pos_z      = mean_pos(rdata.pos_z, item_q.pos_z);
    merged.confidence = mean_u16(rdata.confidence, item_q.confidence);
    merged.extent     = mean_u16(rdata.extent, item_q.extent);
  end

  assign wdata = cmd_i.merge_wr ? merged : item_q;

  noam_ram #(
    .WIDTH ($bits(noam_item_t)),
    .DEPTH (MAX_OBJECTS)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (rdata)
  );

  // distance pipeline: read, abs diff, square, sum, compare
  logic             v0_q, v1_q, v2_q, v3_q;
  logic             m1_q, m2_q, m3_q;
  logic [IDX_W-1:0] idx0_q, idx1_q, idx2_q, idx3_q;
  logic [POS_W-1:0] dx_q, dy_q, dz_q;
  logic [SQ_W-1:0]  sx_q, sy_q, sz_q;
  logic [DIST_W-1:0] dist_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v0_q <= cmd_i.scan;
      v1_q <= v0_q;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    idx0_q <= scan_cnt_q[IDX_W-1:0];
    idx1_q <= idx0_q;
    m1_q   <= (rdata.category == item_q.category);
    dx_q   <= abs_diff(item_q.pos_x, rdata.pos_x);
    dy_q   <= abs_diff(item_q.pos_y, rdata.pos_y);
    dz_q   <= abs_diff(item_q.pos_z, rdata.pos_z);
    idx2_q <= idx1_q;
    m2_q   <= m1_q;
    sx_q   <= SQ_W'(dx_q) * SQ_W'(dx_q);
    sy_q   <= SQ_W'(dy_q) * SQ_W'(dy_q);
    sz_q   <= SQ_W'(dz_q) * SQ_W'(dz_q);
    idx3_q <= idx2_q;
    m3_q   <= m2_q;
    dist_q <= DIST_W'(sx_q) + DIST_W'(sy_q) + DIST_W'(sz_q);
  end

  // nearest tracker, first index wins on a tie
  logic upd;
  assign upd = v3_q && m3_q && (!found_q || (dist_q < best_d_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (cmd_i.load) begin
      found_q <= 1'b0;
    end else if (upd) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd) begin
      best_d_q   <= dist_q;
      best_idx_q <= idx3_q;
    end
  end

  assign sts_o.scan_done = (scan_cnt_q == count_q);
  assign sts_o.pipe_busy = v0_q || v1_q || v2_q || v3_q;
  assign sts_o.match     = found_q && (best_d_q < DIST_W'(r2_q));
  assign sts_o.full      = (count_q == CNT_W'(MAX_OBJECTS));

  // result register
  logic             result_valid_q;
  noam_result_t     result_q;
  logic [CNT_W-1:0] best_id, new_id;

  assign best_id = CNT_W'(best_idx_q) + 1'b1;
  assign new_id  = count_q + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_valid_q <= 1'b0;
    end else begin
      result_valid_q <= cmd_i.merge_wr || cmd_i.append_wr || cmd_i.report_full;
    end
  end

  always_ff @(posedge clk_i) begin
    priority if (cmd_i.merge_wr) begin
      result_q.entry_num  <= OBJ_ID_W'(best_id);
      result_q.was_merged <= 1'b1;
      result_q.table_full <= 1'b0;
    end else if (cmd_i.append_wr) begin
      result_q.entry_num  <= OBJ_ID_W'(new_id);
      result_q.was_merged <= 1'b0;
      result_q.table_full <= 1'b0;
    end else if (cmd_i.report_full) begin
      result_q.entry_num  <= '0;
      result_q.was_merged <= 1'b0;
      result_q.table_full <= 1'b1;
    end else begin
      result_q <= result_q;
    end
  end

  assign result_valid_o = result_valid_q;
  assign result_o       = result_q;

  `NOAM_ASSERT_IMPLIES(a_no_append_full, cmd_i.append_wr, !sts_o.full, "append into full table")
  `NOAM_ASSERT(a_count_bound, count_q <= CNT_W'(MAX_OBJECTS), "entry count beyond depth")
  `NOAM_ASSERT_NEXT(a_merge_reported, cmd_i.merge_wr,
                    result_valid_q && result_q.was_merged, "merge not reported")

endmodule

FILE: hw/rtl/nearest_object_associate_merge_core.sv
// ----------------------------------------------------------------------------
// nearest_object_associate_merge_core
// associates a detected object with the nearest stored object of its class
// and merges into it, or appends it as a new object
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low. The stored objects are
// read from the entry memory one per cycle, through a four-stage distance
// pipeline; after it drains the nearest match within the radius is merged,
// else the item is appended, or table_full is reported if the table is full.
// The result is shown for one cycle on result_o with result_valid_o and cannot
// be held off; busy falls as the strobe rises, so the next start may be given
// in that same cycle. Radius registers are to be written on the cfg port
// while idle, a rule on the user that the block itself does not enforce.
// ----------------------------------------------------------------------------
module nearest_object_associate_merge_core import noam_pkg::*; #(
  parameter int unsigned MAX_OBJECTS = MAX_OBJECTS_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  noam_item_t           item_i,
  output logic                 result_valid_o,
  output noam_result_t         result_o,
  input  logic                 cfg_valid_i,
  output logic                 cfg_ready_o,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [W16-1:0]       cfg_data_i
);

  noam_cmd_t cmd;
  noam_sts_t sts;

  noam_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .busy_o  (busy),
    .sts_i   (sts),
    .cmd_o   (cmd)
  );

  noam_dp #(
    .MAX_OBJECTS (MAX_OBJECTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .item_i         (item_i),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o)
  );

endmodule

FILE: test/tb_nearest_object_associate_merge_core.sv
// ----------------------------------------------------------------------------
// tb_nearest_object_associate_merge_core
// self-checking bench: detections go in through start/busy and the radius
// registers through the cfg channel. A software object table predicts each
// entry_num/was_merged/table_full report, and every strobed report is compared
// with the oldest prediction. A directed run comes first, then random phases
// under several radius settings until the table is full and past it.
// ----------------------------------------------------------------------------
module tb_nearest_object_associate_merge_core;
  import noam_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 5000;
  localparam int PHASE_ITEMS = 157;

  class object_table_model;
    logic [CLASS_W-1:0]      obj_class  [MAX_OBJECTS_DEF];
    logic signed [POS_W-1:0] obj_x      [MAX_OBJECTS_DEF];
    logic signed [POS_W-1:0] obj_y      [MAX_OBJECTS_DEF];
    logic signed [POS_W-1:0] obj_z      [MAX_OBJECTS_DEF];
    logic [W16-1:0]          obj_conf   [MAX_OBJECTS_DEF];
    logic [W16-1:0]          obj_extent [MAX_OBJECTS_DEF];
    int unsigned             count;
    logic [W16-1:0]          radius [4];
    noam_result_t            expected_reports [$];
    int                      errors;

    function new();
      count = 0;
      errors = 0;
      radius[CFG_RADIUS_DEFAULT] = RADIUS_DEFAULT_RST;
      radius[CFG_RADIUS_BOTTLE]  = RADIUS_BOTTLE_RST;
      radius[CFG_RADIUS_CHAIR]   = RADIUS_CHAIR_RST;
      radius[CFG_RADIUS_MONITOR] = RADIUS_MONITOR_RST;
    endfunction

    function void set_radius(cfg_reg_e idx, logic [W16-1:0] val);
      radius[idx] = val;
    endfunction

    function logic [W16-1:0] radius_of(logic [CLASS_W-1:0] cls);
      case (cls)
        CLASS_BOTTLE:  return radius[CFG_RADIUS_BOTTLE];
        CLASS_CHAIR:   return radius[CFG_RADIUS_CHAIR];
        CLASS_MONITOR: return radius[CFG_RADIUS_MONITOR];
        default:       return radius[CFG_RADIUS_DEFAULT];
      endcase
    endfunction

    function int pending();
      return expected_reports.size();
    endfunction

    function void note_detection(noam_item_t it);
      int           n;
      int           best;
      longint       best_d;
      longint       sq_d;
      longint       dx;
      longint       dy;
      longint       dz;
      longint       r2;
      noam_result_t rep;
      n = int'(count);
      best = -1;
      best_d = 0;
      for (int i = 0; i < n; i++) begin
        if (obj_class[i] != it.category) continue;
        dx = longint'(obj_x[i]) - longint'($signed(it.pos_x));
        dy = longint'(obj_y[i]) - longint'($signed(it.pos_y));
        dz = longint'(obj_z[i]) - longint'($signed(it.pos_z));
        sq_d = dx * dx + dy * dy + dz * dz;
        if (best < 0 || sq_d < best_d) begin
          best = i;
          best_d = sq_d;
        end
      end
      r2 = longint'(radius_of(it.category)) * longint'(radius_of(it.category));
      rep = '0;
      if (best >= 0 && best_d < r2) begin
        obj_x[best] = POS_W'((longint'(obj_x[best]) + longint'($signed(it.pos_x))) >>> 1);
        obj_y[best] = POS_W'((longint'(obj_y[best]) + longint'($signed(it.pos_y))) >>> 1);
        obj_z[best] = POS_W'((longint'(obj_z[best]) + longint'($signed(it.pos_z))) >>> 1);
        obj_conf[best] = W16'((int'(obj_conf[best]) + int'(it.confidence)) >> 1);
        obj_extent[best] = W16'((int'(obj_extent[best]) + int'(it.extent)) >> 1);
        rep.entry_num = OBJ_ID_W'(best + 1);
        rep.was_merged = 1'b1;
      end else if (n >= MAX_OBJECTS_DEF) begin
        rep.table_full = 1'b1;
      end else begin
        obj_class[n] = it.category;
        obj_x[n] = it.pos_x;
        obj_y[n] = it.pos_y;
        obj_z[n] = it.pos_z;
        obj_conf[n] = it.confidence;
        obj_extent[n] = it.extent;
        count = n + 1;
        rep.entry_num = OBJ_ID_W'(n + 1);
      end
      expected_reports.insert(expected_reports.size(), rep);
    endfunction

    function void check_report(noam_result_t got);
      noam_result_t want;
      if (expected_reports.size() == 0) begin
        $error("unexpected report: entry_num %0d", got.entry_num);
        errors++;
        return;
      end
      want = expected_reports.pop_front();
      if (got.entry_num !== want.entry_num) begin
        $error("entry_num: expected %0d, got %0d", want.entry_num, got.entry_num);
        errors++;
      end
      if (got.was_merged !== want.was_merged) begin
        $error("was_merged: expected %0d, got %0d", want.was_merged, got.was_merged);
        errors++;
      end
      if (got.table_full !== want.table_full) begin
        $error("table_full: expected %0d, got %0d", want.table_full, got.table_full);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 start;
  logic                 busy;
  noam_item_t           item_i;
  logic                 result_valid_o;
  noam_result_t         result_o;
  logic                 cfg_valid_i;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [W16-1:0]       cfg_data_i;

  object_table_model model;
  int                idle_cycles = 0;

  nearest_object_associate_merge_core dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .item_i         (item_i),
    .result_valid_o (result_valid_o),
    .result_o       (result_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && result_valid_o === 1'b1) begin
      model.check_report(result_o);
    end
  end

  always @(posedge clk_i) begin
    if ((start && busy === 1'b0) || result_valid_o === 1'b1 ||
        (cfg_valid_i && cfg_ready_o === 1'b1)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_nearest_object_associate_merge_core: errors");
      $finish;
    end
  end

  function automatic noam_item_t detection(int cls, int x, int y, int z, int conf, int ext);
    noam_item_t it;
    it.category = CLASS_W'(cls);
    it.pos_x = POS_W'(x);
    it.pos_y = POS_W'(y);
    it.pos_z = POS_W'(z);
    it.confidence = W16'(conf);
    it.extent = W16'(ext);
    return it;
  endfunction

  function automatic logic [POS_W-1:0] extreme_pos();
    case ($urandom_range(0, 3))
      0:       return {1'b0, {(POS_W-1){1'b1}}};
      1:       return {1'b1, {(POS_W-1){1'b0}}};
      2:       return '0;
      default: return '1;
    endcase
  endfunction

  function automatic logic [POS_W-1:0] near_pos(logic signed [POS_W-1:0] base, int span);
    int d;
    d = int'($urandom_range(0, 2 * span)) - span;
    return POS_W'(int'(base) + d);
  endfunction

  function automatic noam_item_t make_detection();
    noam_item_t  it;
    int          sel;
    int          k;
    int          span;
    int unsigned r;
    it = '0;
    sel = $urandom_range(0, 99);
    it.confidence = W16'($urandom);
    it.extent = W16'($urandom);
    if ($urandom_range(0, 9) == 0) it.confidence = $urandom_range(0, 1) ? '1 : '0;
    if ($urandom_range(0, 9) == 0) it.extent = $urandom_range(0, 1) ? '1 : '0;
    if (model.count > 0 && sel < 74) begin
      k = $urandom_range(0, model.count - 1);
      it.category = model.obj_class[k];
      if (sel < 64) begin
        r = model.radius_of(it.category);
        span = int'((r * 3) / 4) + 1;
        it.pos_x = near_pos(model.obj_x[k], span);
        it.pos_y = near_pos(model.obj_y[k], span);
        it.pos_z = near_pos(model.obj_z[k], span);
      end else begin
        it.pos_x = model.obj_x[k];
        it.pos_y = model.obj_y[k];
        it.pos_z = model.obj_z[k];
      end
    end else begin
      k = $urandom_range(0, 99);
      if (k < 20) begin
        case ($urandom_range(0, 2))
          0:       it.category = CLASS_BOTTLE;
          1:       it.category = CLASS_CHAIR;
          default: it.category = CLASS_MONITOR;
        endcase
      end else if (k < 85) begin
        it.category = CLASS_W'($urandom_range(0, 20));
      end else begin
        it.category = CLASS_W'($urandom_range(21, 31));
      end
      if (sel < 90) begin
        it.pos_x = near_pos('0, 16384);
        it.pos_y = near_pos('0, 16384);
        it.pos_z = near_pos('0, 16384);
      end else if (sel < 96) begin
        it.pos_x = POS_W'($urandom);
        it.pos_y = POS_W'($urandom);
        it.pos_z = POS_W'($urandom);
      end else begin
        it.pos_x = extreme_pos();
        it.pos_y = extreme_pos();
        it.pos_z = extreme_pos();
      end
    end
    return it;
  endfunction

  task automatic send_detection(input noam_item_t it);
    start <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy !== 1'b0);
    model.note_detection(it);
  endtask

  task automatic settle();
    start <= 1'b0;
    while (model.pending() != 0) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic program_radii(input logic [W16-1:0] r_default, input logic [W16-1:0] r_bottle,
                               input logic [W16-1:0] r_chair, input logic [W16-1:0] r_monitor);
    cfg_reg_e       idx [4];
    logic [W16-1:0] val [4];
    idx = '{CFG_RADIUS_DEFAULT, CFG_RADIUS_BOTTLE, CFG_RADIUS_CHAIR, CFG_RADIUS_MONITOR};
    val = '{r_default, r_bottle, r_chair, r_monitor};
    for (int k = 0; k < 4; k++) begin
      cfg_valid_i <= 1'b1;
      cfg_index_i <= idx[k];
      cfg_data_i <= val[k];
      do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
      model.set_radius(idx[k], val[k]);
    end
    cfg_valid_i <= 1'b0;
  endtask

  task automatic run_items(input int total);
    int left;
    int burst;
    int gap;
    left = total;
    while (left > 0) begin
      burst = $urandom_range(1, 24);
      if (burst > left) burst = left;
      for (int j = 0; j < burst; j++) send_detection(make_detection());
      left -= burst;
      case ($urandom_range(0, 5))
        0, 1:    gap = 0;
        2:       gap = $urandom_range(20, 90);
        default: gap = $urandom_range(1, 8);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  initial begin
    model = new();
    rst_ni = 1'b0;
    start = 1'b0;
    item_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = '0;
    cfg_data_i = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: merges, strict radius edge, field extremes, classes past the last one
    send_detection(detection(0, 0, 0, 0, 0, 0));
    send_detection(detection(0, 300, -200, 100, 65535, 65535));
    send_detection(detection(5, 8388607, 8388607, 8388607, 65535, 65535));
    send_detection(detection(5, 8388507, 8388507, 8388507, 1, 0));
    send_detection(detection(5, -8388608, -8388608, -8388608, 0, 65535));
    send_detection(detection(9, -1, -1, -1, 32768, 1));
    send_detection(detection(20, 1000, 0, 0, 100, 200));
    send_detection(detection(20, 1512, 0, 0, 300, 400));
    send_detection(detection(20, 489, 0, 0, 65535, 0));
    send_detection(detection(31, 0, 0, 0, 7, 7));
    send_detection(detection(21, 0, 0, 0, 9, 9));
    send_detection(detection(31, 600, 0, 0, 1, 65534));
    settle();

    // zero radius: identical detections are appended twice
    program_radii('0, '0, '0, '0);
    send_detection(detection(3, 7, -7, 7, 1000, 2000));
    send_detection(detection(3, 7, -7, 7, 3000, 4000));
    settle();

    // widest radius: tie goes to the lower id
    program_radii('1, '1, '1, '1);
    send_detection(detection(3, 7, -7, 7, 65535, 65535));
    send_detection(detection(5, -8323074, -8388608, -8388608, 5, 5));
    send_detection(detection(0, 0, 0, 0, 32768, 4660));
    settle();

    for (int p = 0; p < 7; p++) begin
      case (p)
        0: program_radii(RADIUS_DEFAULT_RST, RADIUS_BOTTLE_RST, RADIUS_CHAIR_RST,
                         RADIUS_MONITOR_RST);
        1: program_radii('1, '1, '1, '1);
        2: program_radii(W16'($urandom_range(1, 4096)), W16'($urandom_range(1, 4096)),
                         W16'($urandom_range(1, 4096)), W16'($urandom_range(1, 4096)));
        3: program_radii(16'd1, 16'd1, 16'd1, 16'd1);
        4: program_radii(W16'($urandom), W16'($urandom), W16'($urandom), W16'($urandom));
        5: program_radii('0, '0, '0, '0);
        default: program_radii('1, '0, '1, '0);
      endcase
      run_items(PHASE_ITEMS);
      settle();
    end

    if (model.errors == 0) begin
      $display("tb_nearest_object_associate_merge_core: clean");
    end else begin
      $display("tb_nearest_object_associate_merge_core: errors");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/noam_pkg.sv
hw/rtl/noam_ram.sv
hw/rtl/noam_ctrl.sv
hw/rtl/noam_dp.sv
hw/rtl/nearest_object_associate_merge_core.sv
test/tb_nearest_object_associate_merge_core.sv
